@@ src/bounded_keyed_record_table_defines.svh @@
// ----------------------------------------------------------------------------
// bounded_keyed_record_table_defines
// Assertion macros used by the top level of the record table RTL.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_KEYED_RECORD_TABLE_DEFINES_SVH
`define BOUNDED_KEYED_RECORD_TABLE_DEFINES_SVH

// same-cycle implication
`define BKRT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication
`define BKRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

@@ src/bkrt_pkg.sv @@
// ----------------------------------------------------------------------------
// bkrt_pkg
// Types, codes and defaults of the keyed record table.
// ----------------------------------------------------------------------------
package bkrt_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int CAP_W         = 5;
   localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

   // operation codes
   localparam logic [2:0] FUNC_ADD    = 3'd0;
   localparam logic [2:0] FUNC_SEARCH = 3'd1;
   localparam logic [2:0] FUNC_REMOVE = 3'd2;
   localparam logic [2:0] FUNC_UNIQUE = 3'd3;
   localparam logic [2:0] FUNC_CLEAR  = 3'd4;

   // result status codes
   localparam logic [1:0] RSP_OK   = 2'd0;
   localparam logic [1:0] RSP_MISS = 2'd1;
   localparam logic [1:0] RSP_FULL = 2'd2;

   typedef struct packed {
      logic [2:0]         func;
      logic signed [31:0] code;
      logic [31:0]        value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  position;
      logic [31:0] found_value;
      logic [4:0]  entry_total;
      logic        is_full;
      logic        is_empty;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic       latch;
      logic       append;
      logic       scan;
      logic       shift;
      logic       dec;
      logic       clear;
      logic       rsp_load;
      logic [1:0] rsp_status;
      logic       rsp_hit;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [2:0] func;
      logic       full;
      logic       hit;
      logic       pending;
      logic       idx_end;
   } stat_type;

endpackage

@@ src/bkrt_ram.sv @@
// ----------------------------------------------------------------------------
// bkrt_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bkrt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/bkrt_datapath.sv @@
// ----------------------------------------------------------------------------
// bkrt_datapath
// Record store, count, capacity register, scan/shift indexes, result register.
// ----------------------------------------------------------------------------
module bkrt_datapath #(
   parameter int DEPTH = bkrt_pkg::DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bkrt_pkg::req_type              req_data,
   input  logic                           csr_wr_en,
   input  logic [bkrt_pkg::CAP_W-1:0]     csr_wr_data,
   input  bkrt_pkg::cmd_type              cmd,
   output bkrt_pkg::stat_type             stat,
   output logic                           rsp_valid,
   output bkrt_pkg::rsp_type              rsp_data
);
   import bkrt_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int WW = (CW > CAP_W) ? CW : CAP_W;

   req_type          req_ff;
   logic [CAP_W-1:0] cap_ff;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    idx_ff;
   logic             pend_ff;
   logic [AW-1:0]    pend_idx_ff;
   logic [AW-1:0]    hit_idx_ff;
   logic [31:0]      hit_val_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   logic [63:0]      rd_data;
   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic [63:0]      ram_wdata;
   logic [WW-1:0]    eff_cap;
   logic             match;
   logic             idx_end;
   logic [AW+3:0]    pos_ext;
   logic [CW+4:0]    total_ext;

   // effective capacity never exceeds the store depth
   assign eff_cap = (WW'(cap_ff) > WW'(DEPTH)) ? WW'(DEPTH) : WW'(cap_ff);
   assign match   = pend_ff && (rd_data[63:32] == req_ff.code);
   assign idx_end = idx_ff >= count_ff;

   assign stat.func    = req_ff.func;
   assign stat.full    = WW'(count_ff) >= eff_cap;
   assign stat.hit     = match;
   assign stat.pending = pend_ff;
   assign stat.idx_end = idx_end;

   assign ram_we    = cmd.append || (cmd.shift && pend_ff);
   assign ram_waddr = cmd.append ? count_ff[AW-1:0] : (pend_idx_ff - AW'(1));
   assign ram_wdata = cmd.append ? {req_ff.code, req_ff.value} : rd_data;

   bkrt_ram #(
      .WIDTH (64),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.append) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAPACITY_RESET;
         count_ff     <= '0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         count_ff     <= count_in;
         rsp_valid_ff <= cmd.rsp_load;
         if (cmd.latch) begin
            idx_ff  <= '0;
            pend_ff <= 1'b0;
         end else if (cmd.scan && match) begin
            // first hit: park the index just past it for compaction
            idx_ff  <= CW'(pend_idx_ff) + CW'(1);
            pend_ff <= 1'b0;
         end else if (cmd.scan || cmd.shift) begin
            if (!idx_end) begin
               idx_ff  <= idx_ff + CW'(1);
               pend_ff <= 1'b1;
            end else begin
               pend_ff <= 1'b0;
            end
         end
      end
   end

   assign pos_ext   = {4'b0, hit_idx_ff};
   assign total_ext = {5'b0, count_ff};

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         req_ff <= req_data;
      end
      if ((cmd.scan || cmd.shift) && !idx_end && !(cmd.scan && match)) begin
         pend_idx_ff <= idx_ff[AW-1:0];
      end
      if (cmd.scan && match) begin
         hit_idx_ff <= pend_idx_ff;
         hit_val_ff <= rd_data[31:0];
      end
      if (cmd.rsp_load) begin
         rsp_ff.status      <= cmd.rsp_status;
         rsp_ff.position    <= cmd.rsp_hit ? pos_ext[3:0] : 4'd0;
         rsp_ff.found_value <= cmd.rsp_hit ? hit_val_ff : 32'd0;
         rsp_ff.entry_total <= total_ext[4:0];
         rsp_ff.is_full     <= WW'(count_ff) >= eff_cap;
         rsp_ff.is_empty    <= count_ff == '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ src/bkrt_ctrl.sv @@
// ----------------------------------------------------------------------------
// bkrt_ctrl
// Sequencer for add, search, remove, uniqueness check and clear.
// ----------------------------------------------------------------------------
module bkrt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  bkrt_pkg::stat_type stat,
   output bkrt_pkg::cmd_type  cmd
);
   import bkrt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_SHIFT,
      ST_FINISH
   } state_type;

   state_type  state_ff, state_in;
   logic       busy_ff, busy_in;
   logic [1:0] code_ff, code_in;
   logic       use_hit_ff, use_hit_in;

   always_comb begin
      state_in   = state_ff;
      busy_in    = busy_ff;
      code_in    = code_ff;
      use_hit_in = use_hit_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               busy_in   = 1'b1;
               state_in  = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            use_hit_in = 1'b0;
            code_in    = RSP_OK;
            state_in   = ST_FINISH;
            unique case (stat.func) inside
               FUNC_ADD: begin
                  if (stat.full) begin
                     code_in = RSP_FULL;
                  end else begin
                     cmd.append = 1'b1;
                  end
               end
               FUNC_SEARCH, FUNC_REMOVE, FUNC_UNIQUE: begin
                  state_in = ST_SCAN;
               end
               FUNC_CLEAR: begin
                  cmd.clear = 1'b1;
               end
               default: begin
               end
            endcase
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.hit) begin
               if (stat.func == FUNC_UNIQUE) begin
                  code_in    = RSP_MISS;
                  use_hit_in = 1'b0;
                  state_in   = ST_FINISH;
               end else begin
                  code_in    = RSP_OK;
                  use_hit_in = 1'b1;
                  state_in   = (stat.func == FUNC_REMOVE) ? ST_SHIFT : ST_FINISH;
               end
            end else if (stat.idx_end) begin
               code_in    = (stat.func == FUNC_UNIQUE) ? RSP_OK : RSP_MISS;
               use_hit_in = 1'b0;
               state_in   = ST_FINISH;
            end
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            if (!stat.pending && stat.idx_end) begin
               cmd.dec  = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.rsp_load   = 1'b1;
            cmd.rsp_status = code_ff;
            cmd.rsp_hit    = use_hit_ff;
            busy_in        = 1'b0;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         busy_ff    <= 1'b0;
         code_ff    <= RSP_OK;
         use_hit_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         busy_ff    <= busy_in;
         code_ff    <= code_in;
         use_hit_ff <= use_hit_in;
      end
   end

   assign busy = busy_ff;

endmodule

@@ src/bounded_keyed_record_table.sv @@
// ----------------------------------------------------------------------------
// bounded_keyed_record_table
// Add, clear and unknown ops go from dispatch straight to the result load.
// Search and check unique scan the records held; the scan
// reads one entry per cycle through the single read port of the record RAM.
// Remove then shifts the records past the hit down one place to close the gap.
// One transaction at a time; start is taken again in the cycle rsp_valid shows.
// Synchronous reset empties the table, sets capacity to 16; RAM is not cleared.
// ----------------------------------------------------------------------------
`include "bounded_keyed_record_table_defines.svh"

module bounded_keyed_record_table #(
   parameter int DEPTH = bkrt_pkg::DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       start,
   output logic                       busy,
   input  bkrt_pkg::req_type          req_data,
   // result channel, one-cycle strobe, no back-pressure
   output logic                       rsp_valid,
   output bkrt_pkg::rsp_type          rsp_data,
   // capacity register
   input  logic                       csr_wr_en,
   input  logic [bkrt_pkg::CAP_W-1:0] csr_wr_data
);
   import bkrt_pkg::*;

   // command / status between sequencer and datapath
   cmd_type  cmd;
   stat_type stat;

   // Sequencer: dispatches the op, runs the linear scan, then the
   // shift-down compaction for remove, and fires the result load.
   bkrt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // Datapath: record RAM (code in the upper word, value in the lower),
   // count, capacity, scan index with a one-deep read pipeline.
   bkrt_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

   // an accepted transaction holds off the next one
   `BKRT_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // the end of a transaction always delivers its result
   `BKRT_ASSERT_NOW(a_done_rsp, clock, reset, $fell(busy), rsp_valid)
   // a result only follows a transaction in flight
   `BKRT_ASSERT_NOW(a_rsp_after_busy, clock, reset, rsp_valid, $past(busy))

endmodule

@@ tb/sv/bounded_keyed_record_table_test.sv @@
// ----------------------------------------------------------------------------
// bounded_keyed_record_table_test
// Self-checking bench for the keyed record table. A shadow copy of the table
// predicts every response; directed tests cover empty, full, duplicate keys,
// compaction, unused op codes and capacity corners. Random traffic then runs
// over a range of capacity settings.
// ----------------------------------------------------------------------------
module bounded_keyed_record_table_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bkrt_pkg::*;

   localparam int TABLE_DEPTH = DEPTH_DEFAULT;
   localparam int HALF_PERIOD = 5;
   localparam int RESET_CYCLES = 11;
   // Slowest correct run is roughly 530 transactions, each with its idle gap
   // and its busy time. The limit allows several times that.
   localparam int CYCLE_LIMIT = 250000;
   // Drain time after the last response: full scan plus full compaction.
   localparam int DRAIN_CYCLES = 48;

   localparam logic [31:0] CODE_MIN = 32'h8000_0000;
   localparam logic [31:0] CODE_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] CODE_ALL_ONES = 32'hFFFF_FFFF;
   localparam logic [31:0] CODE_DUP = 32'h0000_0055;
   localparam logic [31:0] VALUE_MAX = 32'hFFFF_FFFF;

   // DUT signals; every input has a known value from time zero
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   req_type             req_data = '0;
   logic                rsp_valid;
   rsp_type             rsp_data;
   logic                csr_wr_en = 1'b0;
   logic [CAP_W-1:0]    csr_wr_data = '0;

   // Shadow table: mirrors the records, count and capacity of the DUT
   logic [31:0]         shadow_code [TABLE_DEPTH];
   logic [31:0]         shadow_value [TABLE_DEPTH];
   int                  shadow_count = 0;
   int                  shadow_capacity = int'(CAPACITY_RESET);

   // Responses predicted at accept time, oldest first
   rsp_type             pending_rsp_q [$];

   int                  error_count = 0;
   int                  txn_count = 0;
   int                  cap_write_count = 0;
   int                  hit_count = 0;
   int                  full_count = 0;
   int                  cycle_count = 0;
   bit                  no_idle = 1'b0;

   bounded_keyed_record_table #(
      .DEPTH(TABLE_DEPTH)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // ------------------------------------------------------------------------
   // Prediction: apply one transaction to the shadow table and return the
   // response the DUT must produce. Capacity is clamped to the table depth;
   // a capacity below the count leaves existing records in place.
   // ------------------------------------------------------------------------
   function automatic rsp_type table_apply(input req_type r);
      rsp_type o;
      int      cap;
      int      hit;
      o = '0;
      cap = (shadow_capacity > TABLE_DEPTH) ? TABLE_DEPTH : shadow_capacity;
      hit = -1;
      // first match only; records past the count are stale
      for (int i = 0; i < shadow_count; i++) begin
         if (hit < 0 && shadow_code[i] == r.code) begin
            hit = i;
         end
      end
      case (r.func)
         FUNC_ADD: begin
            if (shadow_count < cap) begin
               shadow_code[shadow_count] = r.code;
               shadow_value[shadow_count] = r.value;
               shadow_count++;
            end else begin
               o.status = RSP_FULL;
            end
         end
         FUNC_SEARCH, FUNC_REMOVE: begin
            if (hit >= 0) begin
               o.position = hit[3:0];
               o.found_value = shadow_value[hit];
               if (r.func == FUNC_REMOVE) begin
                  // close the gap, keep order
                  for (int i = hit; i + 1 < shadow_count; i++) begin
                     shadow_code[i] = shadow_code[i + 1];
                     shadow_value[i] = shadow_value[i + 1];
                  end
                  shadow_count--;
               end
            end else begin
               o.status = RSP_MISS;
            end
         end
         FUNC_UNIQUE: begin
            if (hit >= 0) begin
               o.status = RSP_MISS;
            end
         end
         FUNC_CLEAR: begin
            shadow_count = 0;
         end
         default: begin
            // unused op codes: no change, status OK
         end
      endcase
      o.entry_total = shadow_count[4:0];
      o.is_full = (shadow_count >= cap);
      o.is_empty = (shadow_count == 0);
      return o;
   endfunction

   // ------------------------------------------------------------------------
   // Send one transaction. The idle gap is drawn at random per transaction,
   // or left out during back-to-back stretches. start stays high
   // across back-to-back transactions so it is never lowered and raised in
   // the same time step.
   // ------------------------------------------------------------------------
   task automatic issue_op(input logic [2:0] func, input logic [31:0] code,
                           input logic [31:0] value);
      req_type r;
      int      gap;
      r.func = func;
      r.code = code;
      r.value = value;
      gap = no_idle ? 0 : $urandom_range(16, 0);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      // accepted at the first edge that sees start high and busy low
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_rsp_q.push_back(table_apply(r));
      txn_count++;
   endtask

   // Capacity is only written with the table idle and no response pending.
   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      start <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      shadow_capacity = int'(cap);
      cap_write_count++;
   endtask

   // ------------------------------------------------------------------------
   // Response checker: every strobe must match the oldest prediction.
   // rsp_valid is sampled at the edge that ends its cycle.
   // ------------------------------------------------------------------------
   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t ERROR %s mismatch: expected %0h, actual %0h",
                  $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp_q.size() == 0) begin
            error_count++;
            $display("%0t ERROR unexpected response: expected none, actual %h",
                     $time, rsp_data);
         end else begin
            want = pending_rsp_q.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_data.status));
            check_field("position", 32'(want.position), 32'(rsp_data.position));
            check_field("found_value", want.found_value, rsp_data.found_value);
            check_field("entry_total", 32'(want.entry_total),
                        32'(rsp_data.entry_total));
            check_field("is_full", 32'(want.is_full), 32'(rsp_data.is_full));
            check_field("is_empty", 32'(want.is_empty), 32'(rsp_data.is_empty));
            if (want.status == RSP_OK && want.found_value != 0) hit_count++;
            if (want.status == RSP_FULL) full_count++;
         end
      end
   end

   // Watchdog: a hang or a lost response ends the run here.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("bounded_keyed_record_table test failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Empty table right after reset: misses, unique, unused op code.
   task automatic test_empty_after_reset();
      issue_op(FUNC_SEARCH, CODE_MIN, $urandom);
      issue_op(FUNC_REMOVE, CODE_MAX, $urandom);
      issue_op(FUNC_UNIQUE, '0, $urandom);
      issue_op(FUNC_CLEAR + 3'd1, CODE_ALL_ONES, VALUE_MAX);
   endtask

   // Fill to full depth with extreme and duplicate keys, overflow, then
   // search and remove a duplicated key so compaction walks most of the table.
   task automatic test_fill_and_compact();
      logic [31:0] code;
      logic [31:0] value;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         case (i)
            0: code = CODE_MIN;
            1: code = CODE_MAX;
            2: code = '0;
            3: code = CODE_ALL_ONES;
            default: code = (i % 5 == 0) ? CODE_DUP : $urandom;
         endcase
         value = (i == 0) ? '0 : (i == 1) ? VALUE_MAX : $urandom;
         issue_op(FUNC_ADD, code, value);
      end
      issue_op(FUNC_ADD, CODE_DUP, $urandom);        // full: rejected
      issue_op(FUNC_SEARCH, CODE_DUP, $urandom);     // first of three copies
      issue_op(FUNC_REMOVE, CODE_DUP, $urandom);     // shifts ten records down
      issue_op(FUNC_SEARCH, CODE_DUP, $urandom);     // next copy, moved down
      issue_op(FUNC_UNIQUE, CODE_MAX, $urandom);     // duplicate
      issue_op(FUNC_REMOVE, CODE_ALL_ONES, $urandom);
      issue_op(FUNC_CLEAR + 3'd2, '0, '0);
      issue_op(FUNC_CLEAR + 3'd3, CODE_MIN, VALUE_MAX);
   endtask

   // Capacity corners: lowered below the count, then zero (full and empty).
   task automatic test_capacity_corners();
      write_capacity(5'd4);
      issue_op(FUNC_ADD, CODE_MIN, $urandom);        // count above capacity
      issue_op(FUNC_CLEAR, $urandom, $urandom);
      write_capacity('0);
      issue_op(FUNC_ADD, CODE_MAX, VALUE_MAX);       // nothing fits
      issue_op(FUNC_SEARCH, CODE_MAX, $urandom);
   endtask

   // Random traffic over several capacity settings. Keys come mostly from a
   // small per-phase pool so searches and removes hit; the rest is noise.
   task automatic test_random_traffic();
      logic [CAP_W-1:0] cap_plan [10] = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5,
                                           5'd2, 5'd16, 5'd3, 5'd8, 5'd16};
      logic [31:0]      key_pool [6];
      logic [2:0]       func;
      logic [31:0]      code;
      logic [31:0]      value;
      int               pick;
      for (int phase = 0; phase < 10; phase++) begin
         if (phase == 6) begin
            write_capacity(CAP_W'($urandom_range(31, 0)));
         end else begin
            write_capacity(cap_plan[phase]);
         end
         foreach (key_pool[k]) begin
            pick = $urandom_range(7, 0);
            key_pool[k] = (pick == 0) ? CODE_MIN : (pick == 1) ? CODE_MAX : $urandom;
         end
         for (int n = 0; n < 50; n++) begin
            // alternate paced and back-to-back stretches
            if (n % 25 == 0) no_idle = ($urandom_range(3, 0) == 0);
            pick = $urandom_range(99, 0);
            if (pick < 35) func = FUNC_ADD;
            else if (pick < 55) func = FUNC_SEARCH;
            else if (pick < 75) func = FUNC_REMOVE;
            else if (pick < 88) func = FUNC_UNIQUE;
            else if (pick < 92) func = FUNC_CLEAR;
            else func = 3'($urandom_range(7, FUNC_CLEAR + 1));
            code = ($urandom_range(9, 0) < 8) ? key_pool[$urandom_range(5, 0)]
                                              : $urandom;
            pick = $urandom_range(19, 0);
            value = (pick == 0) ? '0 : (pick == 1) ? VALUE_MAX : $urandom;
            issue_op(func, code, value);
         end
      end
      no_idle = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      no_idle = 1'($urandom_range(1, 0));
      test_empty_after_reset();
      test_fill_and_compact();
      test_capacity_corners();
      test_random_traffic();

      // let the last transaction drain, then make sure nothing else shows
      start <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_rsp_q.size() != 0) begin
         error_count++;
         $display("%0t ERROR %0d responses missing: expected 0 pending, actual %0d",
                  $time, pending_rsp_q.size(), pending_rsp_q.size());
      end

      $display("Ran %0d transactions across %0d capacity writes (0, 1, 16, 31 and more).",
               txn_count, cap_write_count);
      $display("Saw %0d nonzero lookups and %0d table-full rejects; %0d mismatches.",
               hit_count, full_count, error_count);
      if (error_count == 0) begin
         $display("bounded_keyed_record_table test passed");
      end else begin
         $display("bounded_keyed_record_table test failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+src
src/bkrt_pkg.sv
src/bkrt_ram.sv
src/bkrt_datapath.sv
src/bkrt_ctrl.sv
src/bounded_keyed_record_table.sv
tb/sv/bounded_keyed_record_table_test.sv
